// ===== rtl/tat_pkg.sv =====
`default_nettype none

package tat_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int ATAN_STEPS      = 16;
	localparam int TABLE_LEN       = 24;
	localparam int TABLE_FRAC      = 30;
	localparam int FORCE_W         = 12;
	localparam int ANGLE_W         = 17;
	localparam int OFFSET_W        = 16;
	localparam int VEC_SHIFT       = 16;
	localparam int VEC_W           = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// How one angle lane is handled by the back end.
	typedef enum logic [2:0] {
		K_ZERO     = 3'd0,
		K_PI       = 3'd1,
		K_HALF_POS = 3'd2,
		K_HALF_NEG = 3'd3,
		K_ROT      = 3'd4,
		K_ROT_PIP  = 3'd5,
		K_ROT_PIN  = 3'd6
	} kind_t;

	typedef enum logic {
		REG_OFFSET_XZ = 1'b0,
		REG_OFFSET_YZ = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		kind_t                     kind_xz;
		kind_t                     kind_yz;
	} item_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic signed [ANGLE_W-1:0] angle_xz;
		logic signed [ANGLE_W-1:0] angle_yz;
	} res_t;

	// atan(2^-i) with 30 fraction bits.
	function automatic longint atan_q30(int i);
		longint v;
		case (i)
			0:       v = 64'sd843314857;
			1:       v = 64'sd497837829;
			2:       v = 64'sd263043837;
			3:       v = 64'sd133525159;
			4:       v = 64'sd67021687;
			5:       v = 64'sd33543516;
			6:       v = 64'sd16775851;
			7:       v = 64'sd8388437;
			8:       v = 64'sd4194283;
			9:       v = 64'sd2097149;
			10:      v = 64'sd1048576;
			11:      v = 64'sd524288;
			12:      v = 64'sd262144;
			13:      v = 64'sd131072;
			14:      v = 64'sd65536;
			15:      v = 64'sd32768;
			16:      v = 64'sd16384;
			17:      v = 64'sd8192;
			18:      v = 64'sd4096;
			19:      v = 64'sd2048;
			20:      v = 64'sd1024;
			21:      v = 64'sd512;
			22:      v = 64'sd256;
			23:      v = 64'sd128;
			default: v = 64'sd0;
		endcase
		return v;
	endfunction

	// Round a nonnegative Q30 value half up to frac fraction bits.
	function automatic longint round_q30(longint v, int frac);
		int sh;
		sh = TABLE_FRAC - frac;
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tat_fifo.sv =====
`default_nettype none

module tat_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("word written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("word taken from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// ===== rtl/tat_front.sv =====
`default_nettype none

module tat_front (
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] x_low,
	input  wire logic [7:0] x_high,
	input  wire logic [7:0] y_low,
	input  wire logic [7:0] y_high,
	input  wire logic [7:0] z_low,
	input  wire logic [7:0] z_high,
	output logic            q_push,
	input  wire logic       q_full,
	output tat_pkg::item_t  q_item
);

	// Raw word divided by 16, rounding toward zero.
	function automatic logic signed [tat_pkg::FORCE_W-1:0] force_of(logic [7:0] lo,
		logic [7:0] hi);
		logic [15:0] w;
		logic [15:0] t;
		w = {hi, lo};
		t = w + (w[15] ? 16'd15 : 16'd0);
		return t[15:4];
	endfunction

	// Pick the handling of atan2(a, b).
	function automatic tat_pkg::kind_t classify(logic signed [tat_pkg::FORCE_W-1:0] a,
		logic signed [tat_pkg::FORCE_W-1:0] b);
		tat_pkg::kind_t k;
		if (a == '0) begin
			k = b[tat_pkg::FORCE_W-1] ? tat_pkg::K_PI : tat_pkg::K_ZERO;
		end else if (b == '0) begin
			k = a[tat_pkg::FORCE_W-1] ? tat_pkg::K_HALF_NEG : tat_pkg::K_HALF_POS;
		end else if (!b[tat_pkg::FORCE_W-1]) begin
			k = tat_pkg::K_ROT;
		end else begin
			k = a[tat_pkg::FORCE_W-1] ? tat_pkg::K_ROT_PIN : tat_pkg::K_ROT_PIP;
		end
		return k;
	endfunction

	logic signed [tat_pkg::FORCE_W-1:0] fx, fy, fz;

	assign fx = force_of(x_low, x_high);
	assign fy = force_of(y_low, y_high);
	assign fz = force_of(z_low, z_high);

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_item.force_x = fx;
		q_item.force_y = fy;
		q_item.force_z = fz;
		q_item.kind_xz = classify(fx, fz);
		q_item.kind_yz = classify(fy, fz);
	end

endmodule

`default_nettype wire

// ===== rtl/tat_back.sv =====
`default_nettype none

module tat_back #(
	parameter int ANGLE_FRAC_BITS = tat_pkg::ANGLE_FRAC_BITS,
	parameter int ATAN_STEPS      = tat_pkg::ATAN_STEPS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_empty,
	output logic                                       in_pop,
	input  wire tat_pkg::item_t                        in_item,
	input  wire logic                                  out_full,
	output logic                                       out_push,
	output tat_pkg::res_t                              out_res,
	input  wire logic signed [tat_pkg::OFFSET_W-1:0]   offset_xz,
	input  wire logic signed [tat_pkg::OFFSET_W-1:0]   offset_yz
);

	localparam int NS    = (ATAN_STEPS > tat_pkg::TABLE_LEN) ? tat_pkg::TABLE_LEN : ATAN_STEPS;
	localparam int ANG_W = ANGLE_FRAC_BITS + 4;
	localparam int VW    = tat_pkg::VEC_W;
	localparam int FW    = tat_pkg::FORCE_W;
	localparam int OW    = tat_pkg::ANGLE_W;
	localparam int SUM_W = ((ANG_W > tat_pkg::OFFSET_W) ? ANG_W : tat_pkg::OFFSET_W) + 2;

	localparam logic signed [ANG_W-1:0] PI_R =
		ANG_W'(tat_pkg::round_q30(tat_pkg::PI_Q30, ANGLE_FRAC_BITS));
	localparam logic signed [ANG_W-1:0] HALF_PI_R =
		ANG_W'(tat_pkg::round_q30(tat_pkg::HALF_PI_Q30, ANGLE_FRAC_BITS));
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (OW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd1 <<< (OW - 1));

	logic adv;
	logic [NS:0] valid_s;

	logic signed [VW-1:0]    x_s   [2][NS];
	logic signed [VW-1:0]    y_s   [2][NS];
	logic                    rot_s [2][NS];
	logic signed [ANG_W-1:0] z_s   [2][NS+1];
	logic signed [FW-1:0]    fx_s  [NS+1];
	logic signed [FW-1:0]    fy_s  [NS+1];
	logic signed [FW-1:0]    fz_s  [NS+1];

	logic signed [tat_pkg::OFFSET_W-1:0] offset [2];

	assign adv    = !out_full;
	assign in_pop = adv && !in_empty;

	assign offset[0] = offset_xz;
	assign offset[1] = offset_yz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NS-1:0], in_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s[0] <= in_item.force_x;
			fy_s[0] <= in_item.force_y;
			fz_s[0] <= in_item.force_z;
		end
	end

	// Entry stage: scale the vector, fold the left half plane over and load the base angle.
	for (genvar l = 0; l < 2; l++) begin : g_entry
		logic signed [FW-1:0]    num;
		tat_pkg::kind_t          kind;
		logic signed [VW-1:0]    x_init, y_init;
		logic signed [ANG_W-1:0] z_init;
		logic                    rot_init;
		logic                    flip;

		assign num  = (l == 0) ? in_item.force_x : in_item.force_y;
		assign kind = (l == 0) ? in_item.kind_xz : in_item.kind_yz;

		always_comb begin
			flip     = 1'b0;
			rot_init = 1'b0;
			z_init   = '0;
			unique case (kind)
				tat_pkg::K_ZERO: begin
					z_init = '0;
				end
				tat_pkg::K_PI: begin
					z_init = PI_R;
				end
				tat_pkg::K_HALF_POS: begin
					z_init = HALF_PI_R;
				end
				tat_pkg::K_HALF_NEG: begin
					z_init = -HALF_PI_R;
				end
				tat_pkg::K_ROT: begin
					rot_init = 1'b1;
				end
				tat_pkg::K_ROT_PIP: begin
					rot_init = 1'b1;
					flip     = 1'b1;
					z_init   = PI_R;
				end
				tat_pkg::K_ROT_PIN: begin
					rot_init = 1'b1;
					flip     = 1'b1;
					z_init   = -PI_R;
				end
				default: begin
					z_init = '0;
				end
			endcase
			x_init = VW'(in_item.force_z) <<< tat_pkg::VEC_SHIFT;
			y_init = VW'(num) <<< tat_pkg::VEC_SHIFT;
			if (flip) begin
				x_init = -x_init;
				y_init = -y_init;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[l][0]   <= x_init;
				y_s[l][0]   <= y_init;
				z_s[l][0]   <= z_init;
				rot_s[l][0] <= rot_init;
			end
		end
	end

	// One vectoring step per stage.
	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam logic signed [ANG_W-1:0] T =
			ANG_W'(tat_pkg::round_q30(tat_pkg::atan_q30(k), ANGLE_FRAC_BITS));

		always_ff @(posedge clk) begin
			if (adv) begin
				fx_s[k+1] <= fx_s[k];
				fy_s[k+1] <= fy_s[k];
				fz_s[k+1] <= fz_s[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [VW-1:0] dx, dy;
			logic                 ypos;

			assign dx   = y_s[l][k] >>> k;
			assign dy   = x_s[l][k] >>> k;
			assign ypos = !y_s[l][k][VW-1];

			always_ff @(posedge clk) begin
				if (adv) begin
					if (!rot_s[l][k]) begin
						z_s[l][k+1] <= z_s[l][k];
					end else if (ypos) begin
						z_s[l][k+1] <= z_s[l][k] + T;
					end else begin
						z_s[l][k+1] <= z_s[l][k] - T;
					end
				end
			end

			if (k < NS - 1) begin : g_vec
				always_ff @(posedge clk) begin
					if (adv) begin
						rot_s[l][k+1] <= rot_s[l][k];
						if (ypos) begin
							x_s[l][k+1] <= x_s[l][k] + dx;
							y_s[l][k+1] <= y_s[l][k] - dy;
						end else begin
							x_s[l][k+1] <= x_s[l][k] - dx;
							y_s[l][k+1] <= y_s[l][k] + dy;
						end
					end
				end
			end
		end
	end

	// Negate, add the offset and clamp into the result field.
	logic signed [SUM_W-1:0] sum [2];
	logic signed [OW-1:0]    ang [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sum[l] = SUM_W'(offset[l]) - SUM_W'(z_s[l][NS]);
			if (sum[l] > SAT_HI) begin
				ang[l] = SAT_HI[OW-1:0];
			end else if (sum[l] < SAT_LO) begin
				ang[l] = SAT_LO[OW-1:0];
			end else begin
				ang[l] = sum[l][OW-1:0];
			end
		end
	end

	assign out_push = adv && valid_s[NS];

	always_comb begin
		out_res.force_x  = fx_s[NS];
		out_res.force_y  = fy_s[NS];
		out_res.force_z  = fz_s[NS];
		out_res.angle_xz = ang[0];
		out_res.angle_yz = ang[1];
	end

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_push && out_full))
		else $error("result pushed while the result queue is full");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_full |=> (valid_s == $past(valid_s)))
		else $error("pipeline moved while stalled");
	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |=> valid_s[0])
		else $error("popped word did not enter the pipeline");

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_angle.sv =====
`default_nettype none

// Path: a pushed word goes through the middle queue, the entry stage and one CORDIC
// stage per step, then into the result queue; the CORDIC is fully pipelined.
// Throughput: one word per cycle while the result queue is not full.
// Reset: arst_n clears the queues, the pipeline valid bits and both offsets to zero;
// no clearing pass is needed, so words are taken as soon as reset is released.

module accel_tilt_angle #(
	parameter int ANGLE_FRAC_BITS = tat_pkg::ANGLE_FRAC_BITS,
	parameter int ATAN_STEPS      = tat_pkg::ATAN_STEPS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Sample side.
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [7:0]                          x_low,
	input  wire logic [7:0]                          x_high,
	input  wire logic [7:0]                          y_low,
	input  wire logic [7:0]                          y_high,
	input  wire logic [7:0]                          z_low,
	input  wire logic [7:0]                          z_high,
	// Result side.
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [tat_pkg::FORCE_W-1:0]       force_x,
	output logic signed [tat_pkg::FORCE_W-1:0]       force_y,
	output logic signed [tat_pkg::FORCE_W-1:0]       force_z,
	output logic signed [tat_pkg::ANGLE_W-1:0]       angle_xz,
	output logic signed [tat_pkg::ANGLE_W-1:0]       angle_yz,
	// Configuration port.
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	// The two angle offsets live at byte addresses 0 and 4, so address bit 2 selects
	// the register and the low bits are ignored.
	logic signed [tat_pkg::OFFSET_W-1:0] offset_xz_q, offset_yz_q;
	tat_pkg::reg_idx_t reg_sel;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = tat_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_xz_q <= '0;
			offset_yz_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				tat_pkg::REG_OFFSET_XZ: offset_xz_q <= pwdata[tat_pkg::OFFSET_W-1:0];
				tat_pkg::REG_OFFSET_YZ: offset_yz_q <= pwdata[tat_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the offset sign-extended to the bus width.
	always_comb begin
		unique case (reg_sel)
			tat_pkg::REG_OFFSET_XZ: prdata = 32'(offset_xz_q);
			tat_pkg::REG_OFFSET_YZ: prdata = 32'(offset_yz_q);
			default:                prdata = '0;
		endcase
	end

	// The front end turns the six bytes into forces and decides, for each angle,
	// whether it is a fixed special value or needs the CORDIC, and from which half plane.
	logic           mid_push, mid_full, mid_pop, mid_empty;
	tat_pkg::item_t mid_wdata, mid_rdata;

	tat_front u_front (
		.push   (push),
		.full   (full),
		.x_low  (x_low),
		.x_high (x_high),
		.y_low  (y_low),
		.y_high (y_high),
		.z_low  (z_low),
		.z_high (z_high),
		.q_push (mid_push),
		.q_full (mid_full),
		.q_item (mid_wdata)
	);

	// A short queue decouples the front end from the back end, so each side can stall
	// without holding up the other.
	tat_fifo #(
		.W     ($bits(tat_pkg::item_t)),
		.DEPTH (tat_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// The back end runs two CORDIC vectoring pipelines side by side, one for each angle,
	// and adds the offsets at the end.
	logic          res_push, res_full;
	tat_pkg::res_t res_wdata, res_rdata;

	tat_back #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.ATAN_STEPS      (ATAN_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_empty  (mid_empty),
		.in_pop    (mid_pop),
		.in_item   (mid_rdata),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_res   (res_wdata),
		.offset_xz (offset_xz_q),
		.offset_yz (offset_yz_q)
	);

	// The result queue holds finished words, so the pipeline keeps flowing while the
	// consumer is slow to pop.
	tat_fifo #(
		.W     ($bits(tat_pkg::res_t)),
		.DEPTH (tat_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop && !empty),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign force_x  = res_rdata.force_x;
	assign force_y  = res_rdata.force_y;
	assign force_z  = res_rdata.force_z;
	assign angle_xz = res_rdata.angle_xz;
	assign angle_yz = res_rdata.angle_yz;

endmodule

`default_nettype wire

// ===== tb/sv/tb_accel_tilt_angle.sv =====
`default_nettype none

module tb_accel_tilt_angle;

	timeunit 1ns;
	timeprecision 1ps;

	// The wait at the end is sized from PIPE_LAT, to give any stray result word
	// time to show up.
	localparam int PIPE_LAT         = tat_pkg::ATAN_STEPS + 2;
	localparam int RANDOM_PER_PHASE = 64;
	localparam int NUM_PHASES       = 6;
	localparam int CYCLE_LIMIT      = 100000;

	// Angle constants are kept with 30 fraction bits and rounded to the output
	// precision by the predictor.
	localparam int     ROUND_SHIFT  = tat_pkg::TABLE_FRAC - tat_pkg::ANGLE_FRAC_BITS;
	localparam longint VEC_SCALE    = 64'sd65536;
	localparam int     OFFSET_LIMIT = 25736;

	// One row of the directed table. The three raw words are split into bytes when
	// driven. Where typed is set, the expected word in the row is used as is.
	// Otherwise the predictor supplies it.
	typedef struct packed {
		logic [15:0]   raw_x;
		logic [15:0]   raw_y;
		logic [15:0]   raw_z;
		logic          typed;
		tat_pkg::res_t want;
	} sample_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        push   = 1'b0;
	logic [7:0]  x_low  = 8'h00;
	logic [7:0]  x_high = 8'h00;
	logic [7:0]  y_low  = 8'h00;
	logic [7:0]  y_high = 8'h00;
	logic [7:0]  z_low  = 8'h00;
	logic [7:0]  z_high = 8'h00;
	logic        pop    = 1'b0;

	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = 3'd0;
	logic [31:0] pwdata  = 32'd0;

	logic                                full;
	logic                                empty;
	logic signed [tat_pkg::FORCE_W-1:0]  force_x;
	logic signed [tat_pkg::FORCE_W-1:0]  force_y;
	logic signed [tat_pkg::FORCE_W-1:0]  force_z;
	logic signed [tat_pkg::ANGLE_W-1:0]  angle_xz;
	logic signed [tat_pkg::ANGLE_W-1:0]  angle_yz;
	logic [31:0]                         prdata;
	logic                                pready;

	// The testbench's own copy of the two offset registers.
	int off_xz = 0;
	int off_yz = 0;

	// Idle rates, in percent of cycles, for the sample side and the result side.
	int src_gap_pct    = 0;
	int sink_stall_pct = 0;

	int fail_count  = 0;
	int cycle_count = 0;

	// Result words the block still owes, oldest first.
	tat_pkg::res_t pending_words [$];

	// atan(2^-i) with 30 fraction bits.
	longint atan_q30_tab [24] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
		64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
		64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
		64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
		64'sd1024,      64'sd512,       64'sd256,       64'sd128
	};

	logic [15:0] extreme_raw [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

	// Directed samples. The first rows are the cases whose answer is plain: all axes
	// zero, full-scale forces, a zero denominator of either sign, a zero numerator
	// over a negative denominator (which gives pi), and raw words that truncate
	// toward zero. Angles there are +-pi/2 = +-12868 and -pi = -25736 with 13 fraction bits,
	// and the offsets are still at their reset value of zero. The later rows cover
	// every quadrant, the diagonals and near-axis vectors, and go to the predictor.
	sample_row_t dir_rows [19] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1'b1,
			{12'sd0, 12'sd0, 12'sd0, 17'sd0, 17'sd0}},
		'{16'h7FFF, 16'h0000, 16'h0000, 1'b1,
			{12'sd2047, 12'sd0, 12'sd0, -17'sd12868, 17'sd0}},
		'{16'h8000, 16'h7FFF, 16'h0000, 1'b1,
			{12'h800, 12'sd2047, 12'sd0, 17'sd12868, -17'sd12868}},
		'{16'h0000, 16'h0000, 16'h8000, 1'b1,
			{12'sd0, 12'sd0, 12'h800, -17'sd25736, -17'sd25736}},
		'{16'hFFFF, 16'hFFF1, 16'hFFF0, 1'b1,
			{12'sd0, 12'sd0, -12'sd1, -17'sd25736, -17'sd25736}},
		'{16'h0000, 16'h0000, 16'h7FFF, 1'b1,
			{12'sd0, 12'sd0, 12'sd2047, 17'sd0, 17'sd0}},
		'{16'h000F, 16'h0010, 16'h0000, 1'b1,
			{12'sd0, 12'sd1, 12'sd0, 17'sd0, -17'sd12868}},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
		'{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
		'{16'h7FFF, 16'h8000, 16'h8000, 1'b0, '0},
		'{16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
		'{16'h0010, 16'hFFF0, 16'hFFF0, 1'b0, '0},
		'{16'hFFF0, 16'h0010, 16'h0010, 1'b0, '0},
		'{16'h0010, 16'hFFF0, 16'h7FFF, 1'b0, '0},
		'{16'h7FFF, 16'h8000, 16'h0010, 1'b0, '0},
		'{16'h8000, 16'h7FFF, 16'hFFF0, 1'b0, '0},
		'{16'h1234, 16'hABCD, 16'h5A5A, 1'b0, '0},
		'{16'hA5C3, 16'h3C5A, 16'hE10F, 1'b0, '0},
		'{16'h00FF, 16'hFF00, 16'h807F, 1'b0, '0}
	};

	accel_tilt_angle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.x_low    (x_low),
		.x_high   (x_high),
		.y_low    (y_low),
		.y_high   (y_high),
		.z_low    (z_low),
		.z_high   (z_high),
		.empty    (empty),
		.pop      (pop),
		.force_x  (force_x),
		.force_y  (force_y),
		.force_z  (force_z),
		.angle_xz (angle_xz),
		.angle_yz (angle_yz),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// A raw register word is signed 16-bit; the force is that word over 16,
	// truncated toward zero as integer division does.
	function automatic int raw_to_force(input logic [15:0] raw);
		return int'($signed(raw)) / 16;
	endfunction

	function automatic longint q30_round(input longint v);
		return (v + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
	endfunction

	// Fixed-point atan2 by CORDIC vectoring. A vector in the left half plane is
	// turned by pi first, so the rotation only ever has to cover -pi/2..pi/2.
	function automatic longint cordic_atan2(input int num, input int den);
		longint vx, vy, acc, base, step_x, step_y;
		int     n_steps, i;
		if (num == 0)
			return (den < 0) ? q30_round(tat_pkg::PI_Q30) : 64'sd0;
		if (den == 0)
			return (num > 0) ? q30_round(tat_pkg::HALF_PI_Q30) :
				-q30_round(tat_pkg::HALF_PI_Q30);
		vx   = longint'(den) * VEC_SCALE;
		vy   = longint'(num) * VEC_SCALE;
		acc  = 0;
		base = 0;
		if (den < 0) begin
			vx   = -vx;
			vy   = -vy;
			base = (num > 0) ? q30_round(tat_pkg::PI_Q30) : -q30_round(tat_pkg::PI_Q30);
		end
		n_steps = (tat_pkg::ATAN_STEPS > 24) ? 24 : tat_pkg::ATAN_STEPS;
		for (i = 0; i < n_steps; i++) begin
			step_x = vy >>> i;
			step_y = vx >>> i;
			if (vy >= 0) begin
				vx  = vx + step_x;
				vy  = vy - step_y;
				acc = acc + q30_round(atan_q30_tab[i]);
			end else begin
				vx  = vx - step_x;
				vy  = vy + step_y;
				acc = acc - q30_round(atan_q30_tab[i]);
			end
		end
		return base + acc;
	endfunction

	// The tilt is the negated angle plus the offset, clamped to the 17-bit field.
	function automatic logic signed [16:0] tilt_angle(input int num, input int den,
			input int off);
		longint v;
		v = -cordic_atan2(num, den) + longint'(off);
		if (v > 65535)
			v = 65535;
		if (v < -65536)
			v = -65536;
		return 17'(v);
	endfunction

	function automatic tat_pkg::res_t predict_word(input logic [15:0] raw_x,
			input logic [15:0] raw_y, input logic [15:0] raw_z);
		tat_pkg::res_t w;
		int            fx, fy, fz;
		fx = raw_to_force(raw_x);
		fy = raw_to_force(raw_y);
		fz = raw_to_force(raw_z);
		w.force_x  = 12'(fx);
		w.force_y  = 12'(fy);
		w.force_z  = 12'(fz);
		w.angle_xz = tilt_angle(fx, fz, off_xz);
		w.angle_yz = tilt_angle(fy, fz, off_yz);
		return w;
	endfunction

	// ---------------------------------------------------------------- sample side

	// Drive one sample and hold it until the block takes it. Idle cycles before the
	// sample are drawn one at a time, so the gaps land on every phase of the
	// pipeline. The expectation is recorded at the edge where the word is taken.
	task automatic send_sample(input logic [15:0] raw_x, input logic [15:0] raw_y,
			input logic [15:0] raw_z, input logic typed, input tat_pkg::res_t want);
		while ($urandom_range(99) < src_gap_pct) begin
			@(negedge clk);
			push = 1'b0;
		end
		@(negedge clk);
		push   = 1'b1;
		x_low  = raw_x[7:0];
		x_high = raw_x[15:8];
		y_low  = raw_y[7:0];
		y_high = raw_y[15:8];
		z_low  = raw_z[7:0];
		z_high = raw_z[15:8];
		do
			@(posedge clk);
		while (full);
		pending_words.push_back(typed ? want : predict_word(raw_x, raw_y, raw_z));
	endtask

	// A raw word whose force comes out as -1, 0 or +1. Raw words between -15 and 15
	// truncate to zero, which is where the zero-numerator and zero-denominator
	// branches of atan2 are hit.
	function automatic logic [15:0] raw_near_zero();
		return 16'(int'($urandom_range(62)) - 31);
	endfunction

	// Every raw word is a legal sample, so half the random samples are plain random
	// bytes. The rest are shaped to land on axes, on full scale, on short vectors
	// where CORDIC rounding matters most, and on the diagonals.
	task automatic send_random_sample();
		logic [15:0] raw [3];
		int          k;
		for (k = 0; k < 3; k++)
			raw[k] = 16'($urandom);
		case ($urandom_range(9))
			5: begin
				raw[0] = raw_near_zero();
				raw[1] = raw_near_zero();
			end
			6: raw[2] = raw_near_zero();
			7: begin
				for (k = 0; k < 3; k++)
					raw[k] = extreme_raw[$urandom_range(3)];
			end
			8: begin
				for (k = 0; k < 3; k++)
					raw[k] = 16'(int'($urandom_range(255)) - 128);
			end
			9: begin
				raw[0] = raw[2];
				raw[1] = -raw[2];
			end
			default: ;
		endcase
		send_sample(raw[0], raw[1], raw[2], 1'b0, '0);
	endtask

	// Stop sending and wait until the block has handed back every word it owes.
	task automatic drain_block();
		@(negedge clk);
		push = 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- configuration

	// Write one offset register, then read it back. The register holds only 16 bits,
	// so only the low 16 bits of the readback are compared.
	task automatic write_offset(input tat_pkg::reg_idx_t idx, input int value);
		logic [31:0] readback;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == tat_pkg::REG_OFFSET_XZ)
			off_xz = value;
		else
			off_yz = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback[15:0] != 16'(value)) begin
			$error("%s readback: expected %0d, got %0d", idx.name(), value,
				$signed(readback[15:0]));
			fail_count++;
		end
	endtask

	function automatic int random_offset();
		return int'($urandom_range(2 * OFFSET_LIMIT)) - OFFSET_LIMIT;
	endfunction

	// ---------------------------------------------------------------- result side

	// The pop decision is made at the falling edge. The word on the result ports is
	// taken, and checked, at the rising edge where pop is high and empty is low.
	always @(negedge clk)
		pop = ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin : check_results
		tat_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_words.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (force_x != want.force_x) begin
					$error("force_x: expected %0d, got %0d", want.force_x, force_x);
					fail_count++;
				end
				if (force_y != want.force_y) begin
					$error("force_y: expected %0d, got %0d", want.force_y, force_y);
					fail_count++;
				end
				if (force_z != want.force_z) begin
					$error("force_z: expected %0d, got %0d", want.force_z, force_z);
					fail_count++;
				end
				if (angle_xz != want.angle_xz) begin
					$error("angle_xz: expected %0d, got %0d", want.angle_xz, angle_xz);
					fail_count++;
				end
				if (angle_yz != want.angle_yz) begin
					$error("angle_yz: expected %0d, got %0d", want.angle_yz, angle_yz);
					fail_count++;
				end
			end
		end
	end

	// A run that stalls, for example because a word never comes back, ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run_sequence
		int r, phase;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples run with the reset offsets of zero, the sender idling in
		// about a quarter of the cycles and the receiver in about half.
		src_gap_pct    = 27;
		sink_stall_pct = 52;
		for (r = 0; r < 19; r++)
			send_sample(dir_rows[r].raw_x, dir_rows[r].raw_y, dir_rows[r].raw_z,
				dir_rows[r].typed, dir_rows[r].want);
		drain_block();

		// Random phases. Each starts with the block drained, which is also where the
		// offsets are rewritten. The first two keep the slow receiver, the next two
		// swap the idle rates, and the last two run with no idling at all.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase < 2) begin
				src_gap_pct    = 27;
				sink_stall_pct = 52;
			end else if (phase < 4) begin
				src_gap_pct    = 52;
				sink_stall_pct = 27;
			end else begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end
			case (phase)
				0: begin
					write_offset(tat_pkg::REG_OFFSET_XZ, OFFSET_LIMIT);
					write_offset(tat_pkg::REG_OFFSET_YZ, -OFFSET_LIMIT);
				end
				1: begin
					write_offset(tat_pkg::REG_OFFSET_XZ, -OFFSET_LIMIT);
					write_offset(tat_pkg::REG_OFFSET_YZ, OFFSET_LIMIT);
				end
				5: begin
					write_offset(tat_pkg::REG_OFFSET_XZ, OFFSET_LIMIT);
					write_offset(tat_pkg::REG_OFFSET_YZ, OFFSET_LIMIT);
				end
				default: begin
					write_offset(tat_pkg::REG_OFFSET_XZ, random_offset());
					write_offset(tat_pkg::REG_OFFSET_YZ, random_offset());
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_random_sample();
			drain_block();
		end

		// Give a stray extra word time to reach the result ports before judging.
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
